### rtl/core/julia_pkg.sv
// Shared types, constants and helper functions for the Julia escape-time pixel block.
// Holds fixed-point widths, register indexes, the sequencer state type and the palette.
// No dependencies.
package julia_pkg;

   // Pixel coordinate and fixed-point format
   localparam int COORD_BITS = 12;
   localparam int FRAC_BITS  = 28;

   // Configuration port
   localparam int CSR_W     = 32;
   localparam int CSR_IDX_W = 3;
   localparam int STEP_W    = 31;
   localparam int ITER_W    = 16;

   // Datapath widths: z spans [-8, +8] so needs FRAC_BITS+5 signed bits
   localparam int Z_W     = FRAC_BITS + 5;
   localparam int MAG_W   = FRAC_BITS + 4;
   localparam int PROD_W  = 2 * MAG_W;
   localparam int SUM_W   = PROD_W + 2;
   localparam int COUNT_W = ITER_W + 1;
   localparam int DIV_W   = ITER_W + 4;
   localparam int IDX_W   = 4;

   // Escape threshold |z|^2 > 4 at 2*FRAC_BITS fraction bits
   localparam logic [PROD_W:0] ESC_LIMIT = (PROD_W + 1)'(1) << (2 * FRAC_BITS + 2);

   // Saturation bounds for z components, +-8
   localparam logic signed [SUM_W-1:0] SAT_HI = $signed(SUM_W'(1) << (FRAC_BITS + 3));
   localparam logic signed [SUM_W-1:0] SAT_LO = -SAT_HI;

   // Palette
   localparam logic [IDX_W-1:0] PAL_SIZE = IDX_W'(12);
   localparam logic [IDX_W-1:0] PAL_LAST = IDX_W'(11);

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_C_REAL   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_C_IMAG   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_X    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_Y    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_STEP_X   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_STEP_Y   = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_ITER = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_SPREAD   = 3'd7;

   // Register reset values
   localparam logic signed [CSR_W-1:0] C_REAL_RST = -32'sd198642237;
   localparam logic signed [CSR_W-1:0] C_IMAG_RST = 32'sd26843546;
   localparam logic signed [CSR_W-1:0] MIN_X_RST  = -32'sd536870912;
   localparam logic signed [CSR_W-1:0] MAX_Y_RST  = 32'sd268435456;
   localparam logic [STEP_W-1:0]       STEP_X_RST = 31'd3579139;
   localparam logic [STEP_W-1:0]       STEP_Y_RST = 31'd3579139;
   localparam logic [ITER_W-1:0]       MAX_ITER_RST = 16'd1000;

   // Sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SETUP,
      ST_START,
      ST_MUL,
      ST_UPD,
      ST_DIV,
      ST_DONE
   } state_type;

   // Clamp a wide signed value to [-8, +8]
   function automatic logic signed [Z_W-1:0] sat_z(input logic signed [SUM_W-1:0] v);
      logic signed [SUM_W-1:0] r;
      begin
         if (v > SAT_HI) begin
            r = SAT_HI;
         end else if (v < SAT_LO) begin
            r = SAT_LO;
         end else begin
            r = v;
         end
         return r[Z_W-1:0];
      end
   endfunction

   // Fixed 12-entry RGB palette
   function automatic logic [23:0] palette_rgb(input logic [IDX_W-1:0] idx);
      logic [23:0] c;
      begin
         case (idx)
            4'd0:    c = 24'heec73e;
            4'd1:    c = 24'hf0a513;
            4'd2:    c = 24'hfb8b00;
            4'd3:    c = 24'hf44800;
            4'd4:    c = 24'hffff99;
            4'd5:    c = 24'hffff00;
            4'd6:    c = 24'hfdca01;
            4'd7:    c = 24'h986601;
            4'd8:    c = 24'hf44800;
            4'd9:    c = 24'hfd3301;
            4'd10:   c = 24'hd40000;
            4'd11:   c = 24'h980101;
            default: c = 24'h000000;
         endcase
         return c;
      end
   endfunction

endpackage

### rtl/core/julia_escape_time_pixel.sv
// Julia-set escape-time pixel colouring: top level with sequencer and shared multiplier unit.
// Depends on julia_pkg (widths, register indexes, state type, saturation and palette).
//
// One pixel enters on the req_ beat and leaves as one rsp_ beat. The pixel is mapped to a
// signed Q4.28 start point, then z = z^2 + c is iterated until |z|^2 > 4 or the count passes
// max_iter. All products go through one unit of three 32x32 multipliers; its output is
// registered, so each iteration is a multiply state followed by an update and escape-test
// state. When palette spreading is on, an escaping pixel then passes through the radix-2
// palette divider; an inside pixel does not. max_iter resets to 1000. req_ready is high only
// while the sequencer is idle, so the next pixel is taken in the cycle after the result is
// loaded at the earliest; a finished result waits in the output register, and the next
// pixel can be taken while it waits. Configuration writes take effect at once and are
// meant for idle.
module julia_escape_time_pixel
   import julia_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // pixel input
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [COORD_BITS-1:0] req_pixel_x,
   input  logic [COORD_BITS-1:0] req_pixel_y,
   // colour result
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [COORD_BITS-1:0] rsp_out_x,
   output logic [COORD_BITS-1:0] rsp_out_y,
   output logic [23:0]           rsp_rgb,
   output logic [IDX_W-1:0]      rsp_palette_index,
   output logic                  rsp_inside_set,
   output logic [COUNT_W-1:0]    rsp_iter_count,
   // configuration writes
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_W-1:0]      csr_wdata
);

   // Configuration registers
   logic signed [CSR_W-1:0] c_real_ff, c_imag_ff, min_x_ff, max_y_ff;
   logic [STEP_W-1:0]       step_x_ff, step_y_ff;
   logic [ITER_W-1:0]       max_iter_ff;
   logic                    spread_ff;

   // Sequencer and datapath registers
   state_type               state_ff, state_in;
   logic [COORD_BITS-1:0]   px_ff, px_in, py_ff, py_in;
   logic signed [Z_W-1:0]   zx_ff, zx_in, zy_ff, zy_in;
   logic [PROD_W-1:0]       prod0_ff, prod0_in, prod1_ff, prod1_in, prod2_ff, prod2_in;
   logic                    xy_neg_ff, xy_neg_in;
   logic                    first_ff, first_in;
   logic [COUNT_W-1:0]      k_ff, k_in, count_ff, count_in;
   logic [IDX_W-1:0]        mod_ff, mod_in, quo_ff, quo_in;
   logic [DIV_W-1:0]        rem_ff, rem_in;
   logic [1:0]              dstep_ff, dstep_in;

   // Output register
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [COORD_BITS-1:0]   out_x_ff, out_x_in, out_y_ff, out_y_in;
   logic [23:0]             rgb_ff, rgb_in;
   logic [IDX_W-1:0]        pidx_ff, pidx_in;
   logic                    inside_ff, inside_in;
   logic [COUNT_W-1:0]      iter_ff, iter_in;

   // Shared multiplier operands and products
   logic [MAG_W-1:0]        mul_a0, mul_b0, mul_a1, mul_b1, mul_a2, mul_b2;
   logic [PROD_W-1:0]       mul_p0, mul_p1, mul_p2;

   // Combinational datapath values
   logic signed [Z_W-1:0]   zx_abs, zy_abs;
   logic [MAG_W-1:0]        mag_x, mag_y;
   logic signed [SUM_W-1:0] x0_sum, y0_sum, sq_diff, nx_sum, xy_s, ny_sum;
   logic [PROD_W:0]         sq_sum;
   logic                    escaped;
   logic [COUNT_W-1:0]      fin_count;
   logic                    fin_go, fin_inside;
   logic [DIV_W-1:0]        div_shift;
   logic                    div_ge;
   logic                    rsp_load;

   // Configuration write port
   always_ff @(posedge clock) begin
      if (reset) begin
         c_real_ff   <= C_REAL_RST;
         c_imag_ff   <= C_IMAG_RST;
         min_x_ff    <= MIN_X_RST;
         max_y_ff    <= MAX_Y_RST;
         step_x_ff   <= STEP_X_RST;
         step_y_ff   <= STEP_Y_RST;
         max_iter_ff <= MAX_ITER_RST;
         spread_ff   <= 1'b0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_C_REAL:   c_real_ff   <= $signed(csr_wdata);
            CSR_C_IMAG:   c_imag_ff   <= $signed(csr_wdata);
            CSR_MIN_X:    min_x_ff    <= $signed(csr_wdata);
            CSR_MAX_Y:    max_y_ff    <= $signed(csr_wdata);
            CSR_STEP_X:   step_x_ff   <= csr_wdata[STEP_W-1:0];
            CSR_STEP_Y:   step_y_ff   <= csr_wdata[STEP_W-1:0];
            CSR_MAX_ITER: max_iter_ff <= csr_wdata[ITER_W-1:0];
            CSR_SPREAD:   spread_ff   <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // Magnitudes of z for the multiplier
   assign zx_abs = zx_ff[Z_W-1] ? -zx_ff : zx_ff;
   assign zy_abs = zy_ff[Z_W-1] ? -zy_ff : zy_ff;
   assign mag_x  = zx_abs[MAG_W-1:0];
   assign mag_y  = zy_abs[MAG_W-1:0];

   // Shared multiplier: pixel scaling during setup, x*x, y*y, |x*y| otherwise
   always_comb begin
      if (state_ff == ST_SETUP) begin
         mul_a0 = MAG_W'(px_ff);
         mul_b0 = MAG_W'(step_x_ff);
         mul_a1 = MAG_W'(py_ff);
         mul_b1 = MAG_W'(step_y_ff);
         mul_a2 = '0;
         mul_b2 = '0;
      end else begin
         mul_a0 = mag_x;
         mul_b0 = mag_x;
         mul_a1 = mag_y;
         mul_b1 = mag_y;
         mul_a2 = mag_x;
         mul_b2 = mag_y;
      end
   end

   assign mul_p0 = PROD_W'(mul_a0) * PROD_W'(mul_b0);
   assign mul_p1 = PROD_W'(mul_a1) * PROD_W'(mul_b1);
   assign mul_p2 = PROD_W'(mul_a2) * PROD_W'(mul_b2);

   // Start point from the scaled pixel
   assign x0_sum = $signed(SUM_W'(prod0_ff)) + SUM_W'(min_x_ff);
   assign y0_sum = SUM_W'(max_y_ff) - $signed(SUM_W'(prod1_ff));

   // z update: floor shifts, add c
   assign sq_diff = $signed(SUM_W'(prod0_ff)) - $signed(SUM_W'(prod1_ff));
   assign nx_sum  = (sq_diff >>> FRAC_BITS) + SUM_W'(c_real_ff);
   assign xy_s    = xy_neg_ff ? -$signed(SUM_W'(prod2_ff)) : $signed(SUM_W'(prod2_ff));
   assign ny_sum  = (xy_s >>> (FRAC_BITS - 1)) + SUM_W'(c_imag_ff);

   // Escape test on the squares of the current z
   assign sq_sum  = {1'b0, prod0_ff} + {1'b0, prod1_ff};
   assign escaped = !first_ff && (sq_sum > ESC_LIMIT);

   // Divider step: compare remainder against shifted limit
   assign div_shift = DIV_W'(max_iter_ff) << dstep_ff;
   assign div_ge    = (rem_ff >= div_shift);

   assign rsp_load = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_ready);

   // Next state and datapath
   always_comb begin
      state_in     = state_ff;
      px_in        = px_ff;
      py_in        = py_ff;
      zx_in        = zx_ff;
      zy_in        = zy_ff;
      prod0_in     = prod0_ff;
      prod1_in     = prod1_ff;
      prod2_in     = prod2_ff;
      xy_neg_in    = xy_neg_ff;
      first_in     = first_ff;
      k_in         = k_ff;
      mod_in       = mod_ff;
      count_in     = count_ff;
      quo_in       = quo_ff;
      rem_in       = rem_ff;
      dstep_in     = dstep_ff;
      fin_go       = 1'b0;
      fin_count    = k_ff;
      req_ready    = 1'b0;

      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      out_x_in     = out_x_ff;
      out_y_in     = out_y_ff;
      rgb_in       = rgb_ff;
      pidx_in      = pidx_ff;
      inside_in    = inside_ff;
      iter_in      = iter_ff;

      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               px_in    = req_pixel_x;
               py_in    = req_pixel_y;
               state_in = ST_SETUP;
            end
         end
         ST_SETUP: begin
            prod0_in  = mul_p0;
            prod1_in  = mul_p1;
            prod2_in  = mul_p2;
            xy_neg_in = 1'b0;
            state_in  = ST_START;
         end
         ST_START: begin
            zx_in    = sat_z(x0_sum);
            zy_in    = sat_z(y0_sum);
            k_in     = '0;
            mod_in   = '0;
            first_in = 1'b1;
            state_in = ST_MUL;
         end
         ST_MUL: begin
            prod0_in  = mul_p0;
            prod1_in  = mul_p1;
            prod2_in  = mul_p2;
            xy_neg_in = zx_ff[Z_W-1] ^ zy_ff[Z_W-1];
            state_in  = ST_UPD;
         end
         ST_UPD: begin
            if (first_ff) begin
               // iteration zero: no test on the start point
               zx_in    = sat_z(nx_sum);
               zy_in    = sat_z(ny_sum);
               first_in = 1'b0;
               state_in = ST_MUL;
            end else if (escaped) begin
               fin_go    = 1'b1;
               fin_count = k_ff;
            end else if (k_ff == COUNT_W'(max_iter_ff)) begin
               fin_go    = 1'b1;
               fin_count = k_ff + COUNT_W'(1);
            end else begin
               k_in     = k_ff + COUNT_W'(1);
               mod_in   = (mod_ff == PAL_LAST) ? '0 : mod_ff + IDX_W'(1);
               zx_in    = sat_z(nx_sum);
               zy_in    = sat_z(ny_sum);
               state_in = ST_MUL;
            end
         end
         ST_DIV: begin
            rem_in   = div_ge ? rem_ff - div_shift : rem_ff;
            quo_in   = {quo_ff[IDX_W-2:0], div_ge};
            dstep_in = dstep_ff - 2'd1;
            if (dstep_ff == 2'd0) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (rsp_load) begin
               rsp_valid_in = 1'b1;
               out_x_in     = px_ff;
               out_y_in     = py_ff;
               inside_in    = (count_ff >= COUNT_W'(max_iter_ff));
               pidx_in      = quo_ff;
               rgb_in       = (count_ff >= COUNT_W'(max_iter_ff)) ? 24'h000000
                                                                  : palette_rgb(quo_ff);
               iter_in      = count_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      // Loop finished: pick palette index directly or start the divider
      fin_inside = (fin_count >= COUNT_W'(max_iter_ff));
      if (fin_go) begin
         count_in = fin_count;
         if (!fin_inside && spread_ff) begin
            rem_in   = DIV_W'(fin_count[ITER_W-1:0]) * DIV_W'(PAL_SIZE);
            quo_in   = '0;
            dstep_in = 2'd3;
            state_in = ST_DIV;
         end else begin
            quo_in   = fin_inside ? '0 : mod_ff;
            state_in = ST_DONE;
         end
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      px_ff     <= px_in;
      py_ff     <= py_in;
      zx_ff     <= zx_in;
      zy_ff     <= zy_in;
      prod0_ff  <= prod0_in;
      prod1_ff  <= prod1_in;
      prod2_ff  <= prod2_in;
      xy_neg_ff <= xy_neg_in;
      first_ff  <= first_in;
      k_ff      <= k_in;
      mod_ff    <= mod_in;
      count_ff  <= count_in;
      quo_ff    <= quo_in;
      rem_ff    <= rem_in;
      dstep_ff  <= dstep_in;
      out_x_ff  <= out_x_in;
      out_y_ff  <= out_y_in;
      rgb_ff    <= rgb_in;
      pidx_ff   <= pidx_in;
      inside_ff <= inside_in;
      iter_ff   <= iter_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_out_x         = out_x_ff;
   assign rsp_out_y         = out_y_ff;
   assign rsp_rgb           = rgb_ff;
   assign rsp_palette_index = pidx_ff;
   assign rsp_inside_set    = inside_ff;
   assign rsp_iter_count    = iter_ff;

   // A pixel beat always starts the setup cycle
   a_accept_setup: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == ST_SETUP))
      else $error("accepted pixel did not enter setup");

   // A finished result waits while the previous one is still held
   a_done_hold: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && rsp_valid_ff && !rsp_ready) |=>
      (state_ff == ST_DONE && rsp_valid_ff))
      else $error("result register overwritten while stalled");

   // z stays within the saturation bounds
   a_z_sat: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MUL) |-> (SUM_W'(zx_ff) <= SAT_HI && SUM_W'(zx_ff) >= SAT_LO &&
                                SUM_W'(zy_ff) <= SAT_HI && SUM_W'(zy_ff) >= SAT_LO))
      else $error("z component outside saturation range");

   // Modulo counter never leaves the palette range
   a_mod_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_UPD) |-> (mod_ff <= PAL_LAST))
      else $error("palette modulo counter out of range");

endmodule
